@@ design/bfns_pkg.sv @@
// package for the bitmap find-next-set engine
// holds sizes, operation codes, sequencer states and the structs between modules
// no dependencies
package bfns_pkg;

   localparam int WORDS  = 32;
   localparam int ADDR_W = $clog2(WORDS);
   localparam int WORD_W = 32;
   localparam int WIU_W  = 6;

   localparam logic [2:0] KIND_GET   = 3'd0;
   localparam logic [2:0] KIND_SET   = 3'd1;
   localparam logic [2:0] KIND_FIND  = 3'd2;
   localparam logic [2:0] KIND_COUNT = 3'd3;
   localparam logic [2:0] KIND_CLEAR = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctl_type;

   typedef struct packed {
      logic       any;
      logic [4:0] idx;
      logic [5:0] ones;
   } scan_res_type;

endpackage

@@ design/bfns_bitmap_mem.sv @@
// bitmap word store: one write port, one registered read port
// per-word valid flags give the all-zero reset and the clear of the whole store
// depends on bfns_pkg
module bfns_bitmap_mem
   import bfns_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mem_ctl_type       ctl,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] bitmap_ff [WORDS];
   logic [WORDS-1:0]  valid_ff;
   logic [WORDS-1:0]  valid_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         bitmap_ff[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff  <= bitmap_ff[ctl.rd_addr];
         rd_valid_ff <= valid_ff[ctl.rd_addr];
      end
   end

   // a word never written since reset or clear reads as zero
   assign rd_data = rd_data_ff & {WORD_W{rd_valid_ff}};

endmodule

@@ design/bfns_scan_unit.sv @@
// shared word unit: on the first word of a scan masks bits below the start offset, counts ones
// and finds the lowest set bit of one 32-bit word
// depends on bfns_pkg
module bfns_scan_unit
   import bfns_pkg::*;
(
   input  logic [WORD_W-1:0] word,
   input  logic [4:0]        offset,
   input  logic              first,
   output scan_res_type      res
);

   logic [WORD_W-1:0] masked;
   logic [5:0]        ones;
   logic [2:0]        nib;
   logic [3:0]        nib_bits;
   logic [1:0]        low;

   function automatic logic [2:0] ones4(input logic [3:0] v);
      ones4 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
   endfunction

   always_comb begin
      masked = first ? (word & ~((32'd1 << offset) - 32'd1)) : word;
      ones = '0;
      for (int n = 0; n < 8; n++) begin
         ones = ones + 6'(ones4(masked[4*n +: 4]));
      end
      // lowest nibble holding a one, then lowest bit inside it
      nib = '0;
      for (int n = 7; n >= 0; n--) begin
         if (|masked[4*n +: 4]) begin
            nib = 3'(n);
         end
      end
      nib_bits = masked[4*nib +: 4];
      low = '0;
      for (int b = 3; b >= 0; b--) begin
         if (nib_bits[b]) begin
            low = 2'(b);
         end
      end
      res.any  = |masked;
      res.idx  = {nib, low};
      res.ones = ones;
   end

endmodule

@@ design/bitmap_find_next_set_engine.sv @@
// top level of the bitmap find-next-set engine: sequencer, words-in-use
// register and result register; uses bfns_bitmap_mem and bfns_scan_unit
// depends on bfns_pkg
//
//  channel | direction | handshake             | word
//  req     | in        | req_valid/req_ready   | kind, position, value
//  rsp     | out       | rsp_valid/rsp_ready   | bit_value, found, found_position, bit_count
//  csr     | in        | csr_valid/csr_ready   | words_in_use
//
// get and set in range read their word once, and set writes it back; clear, unused
// kinds, out-of-range get or set and a scan with no word to read issue no read
// find next and count read one word per cycle through the single memory read port
// and the shared word unit until the scan reaches its last word; a find next that stops
// on a hit drops the read it has already issued
// reset clears the bitmap through per-word valid flags, no sweep
// a result waiting on rsp_ready does not block the next accept; it stalls the
// hand-over of the following result, and no new word is taken until that hand-over
module bitmap_find_next_set_engine
   import bfns_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_kind,
   input  logic signed [10:0] req_position,
   input  logic              req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_bit_value,
   output logic              rsp_found,
   output logic [9:0]        rsp_found_position,
   output logic [10:0]       rsp_bit_count,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WIU_W-1:0]  csr_words_in_use
);

   state_type state_ff, state_in;

   logic [WIU_W-1:0]  wiu_ff, wiu_in;
   logic [WIU_W-1:0]  active;
   logic [10:0]       bits;

   logic [2:0]        kind_ff, kind_in;
   logic              value_ff, value_in;
   logic [4:0]        bitsel_ff, bitsel_in;
   logic [WIU_W-1:0]  first_addr_ff, first_addr_in;
   logic [WIU_W-1:0]  addr_ff, addr_in;
   logic [WIU_W-1:0]  limit_ff, limit_in;
   logic              pend_ff, pend_in;
   logic [WIU_W-1:0]  eval_addr_ff, eval_addr_in;
   logic              bit_ff, bit_in;
   logic              found_ff, found_in;
   logic [9:0]        fpos_ff, fpos_in;
   logic [10:0]       cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_bit_ff, rsp_bit_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [9:0]        rsp_fpos_ff, rsp_fpos_in;
   logic [10:0]       rsp_cnt_ff, rsp_cnt_in;

   logic              accept;
   logic              issue;
   logic              hit;
   logic              load;
   logic [10:0]       start;
   logic              in_range;
   logic [WIU_W-1:0]  pos_word;
   logic [WIU_W-1:0]  start_word;
   logic [WORD_W-1:0] rd_data;
   logic [WORD_W-1:0] bit_mask;
   mem_ctl_type       mem_ctl;
   scan_res_type      scan_res;

   bfns_bitmap_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_data (rd_data)
   );

   bfns_scan_unit u_scan (
      .word   (rd_data),
      .offset (bitsel_ff),
      .first  (eval_addr_ff == first_addr_ff),
      .res    (scan_res)
   );

   // words in use saturates at the store depth
   assign active = (wiu_ff > WIU_W'(WORDS)) ? WIU_W'(WORDS) : wiu_ff;
   assign bits   = {active, 5'b0};

   assign accept     = req_valid && req_ready;
   assign pos_word   = {1'b0, req_position[9:5]};
   assign in_range   = !req_position[10] && (pos_word < active);
   assign start      = req_position[10] ? 11'd0 : (11'(req_position) + 11'd1);
   assign start_word = start[10:5];

   assign issue = (state_ff == ST_SCAN) && (addr_ff < limit_ff);
   assign hit   = pend_ff && ((kind_ff == KIND_GET) || (kind_ff == KIND_SET) ||
                              ((kind_ff == KIND_FIND) && scan_res.any));
   assign load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);
   assign bit_mask = 32'd1 << bitsel_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit || (!issue && !pend_ff)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and memory control
   always_comb begin
      req_ready = 1'b0;
      mem_ctl   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            mem_ctl.clear = req_valid && (req_kind == KIND_CLEAR);
         end
         ST_SCAN: begin
            mem_ctl.rd_en   = issue;
            mem_ctl.rd_addr = addr_ff[ADDR_W-1:0];
            mem_ctl.wr_en   = pend_ff && (kind_ff == KIND_SET);
            mem_ctl.wr_addr = eval_addr_ff[ADDR_W-1:0];
            mem_ctl.wr_data = value_ff ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // operation registers
   always_comb begin
      kind_in       = kind_ff;
      value_in      = value_ff;
      bitsel_in     = bitsel_ff;
      first_addr_in = first_addr_ff;
      addr_in       = addr_ff;
      limit_in      = limit_ff;
      eval_addr_in  = addr_ff;
      pend_in       = issue;
      bit_in        = bit_ff;
      found_in      = found_ff;
      fpos_in       = fpos_ff;
      cnt_in        = cnt_ff;
      if (accept) begin
         kind_in   = req_kind;
         value_in  = req_value;
         bit_in    = 1'b0;
         found_in  = 1'b0;
         fpos_in   = '0;
         cnt_in    = '0;
         bitsel_in = '0;
         addr_in   = '0;
         limit_in  = '0;
         unique case (req_kind) inside
            KIND_GET, KIND_SET: begin
               bitsel_in = req_position[4:0];
               addr_in   = pos_word;
               limit_in  = in_range ? (pos_word + WIU_W'(1)) : pos_word;
            end
            KIND_FIND: begin
               bitsel_in = start[4:0];
               addr_in   = start_word;
               limit_in  = (start_word < active) ? active : start_word;
            end
            KIND_COUNT: begin
               limit_in = active;
            end
            default: begin
            end
         endcase
         first_addr_in = addr_in;
      end else if (issue) begin
         addr_in = addr_ff + WIU_W'(1);
      end
      if (pend_ff && (state_ff == ST_SCAN)) begin
         unique case (kind_ff) inside
            KIND_GET: begin
               bit_in = rd_data[bitsel_ff];
            end
            KIND_FIND: begin
               if (scan_res.any) begin
                  found_in = 1'b1;
                  fpos_in  = {eval_addr_ff[4:0], scan_res.idx};
               end
            end
            KIND_COUNT: begin
               cnt_in = cnt_ff + 11'(scan_res.ones);
            end
            default: begin
            end
         endcase
      end
      // stop after a hit; an extra read already issued is simply dropped
      if (hit) begin
         pend_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bit_in   = rsp_bit_ff;
      rsp_found_in = rsp_found_ff;
      rsp_fpos_in  = rsp_fpos_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_bit_in   = bit_ff;
         rsp_found_in = found_ff;
         rsp_fpos_in  = fpos_ff;
         rsp_cnt_in   = '0;
         if (kind_ff == KIND_COUNT) begin
            rsp_cnt_in = value_ff ? cnt_ff : (bits - cnt_ff);
         end
      end
   end

   assign csr_ready = 1'b1;
   assign wiu_in    = (csr_valid && csr_ready) ? csr_words_in_use : wiu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wiu_ff       <= WIU_W'(32);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wiu_ff       <= wiu_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      bitsel_ff     <= bitsel_in;
      first_addr_ff <= first_addr_in;
      addr_ff       <= addr_in;
      limit_ff      <= limit_in;
      eval_addr_ff  <= eval_addr_in;
      bit_ff        <= bit_in;
      found_ff      <= found_in;
      fpos_ff       <= fpos_in;
      cnt_ff        <= cnt_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bit_value      = rsp_bit_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_bit_count      = rsp_cnt_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("engine ready again right after accepting a word");

   a_pend_from_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ($past(state_ff) == ST_SCAN))
      else $error("read data pending without a scan read");

   a_found_only_find: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESP) && found_ff) |-> (kind_ff == KIND_FIND))
      else $error("found flag set for an operation other than find next");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESP) && (kind_ff == KIND_COUNT)) |-> (cnt_ff <= bits))
      else $error("ones count exceeds active bits");

endmodule

@@ test/testbench.sv @@
// self-checking testbench for bitmap_find_next_set_engine: random and directed get, set,
// find-next, count and clear words against a shadow bitmap, across many words-in-use settings
// depends on bfns_pkg and the design files under design/
module testbench
   import bfns_pkg::*;
();

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_OPS  = 180;

   typedef struct packed {
      logic       bit_value;
      logic       found;
      logic [9:0] found_position;
      logic [10:0] bit_count;
   } bitmap_result_type;

   typedef struct {
      logic [2:0]        kind;
      logic signed [10:0] position;
      logic              value;
      int                gap;
   } bitmap_op_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_kind = '0;
   logic signed [10:0] req_position = '0;
   logic              req_value = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_bit_value;
   logic              rsp_found;
   logic [9:0]        rsp_found_position;
   logic [10:0]       rsp_bit_count;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [WIU_W-1:0]  csr_words_in_use = '0;

   // shadow copy of the bitmap and the active word count
   logic [WORD_W-1:0] shadow_map [WORDS];
   int                shadow_words_in_use = 32;

   bitmap_op_type     op_queue[$];
   bitmap_result_type expected_results[$];
   int                results_due = 0;
   int                mismatch_count = 0;
   int                req_gap_count = 0;
   int                rsp_stall = 0;
   bit                rsp_stalls_on = 1'b1;
   int                stall_cycles = 0;

   bitmap_find_next_set_engine dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bit_value      (rsp_bit_value),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position),
      .rsp_bit_count      (rsp_bit_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_words_in_use   (csr_words_in_use)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int active_bits();
      return ((shadow_words_in_use > WORDS) ? WORDS : shadow_words_in_use) * 32;
   endfunction

   // applies one word to the shadow bitmap and returns the result it should produce
   function automatic bitmap_result_type run_bitmap_op(logic [2:0] kind,
                                                       logic signed [10:0] position,
                                                       logic value);
      bitmap_result_type r;
      int limit;
      int p;
      int i;
      int ones;
      r = '0;
      limit = active_bits();
      p = position;
      ones = 0;
      case (kind)
         KIND_GET: begin
            if (p >= 0 && p < limit) r.bit_value = shadow_map[p >> 5][p & 31];
         end
         KIND_SET: begin
            if (p >= 0 && p < limit) shadow_map[p >> 5][p & 31] = value;
         end
         KIND_FIND: begin
            // search is exclusive of the start, anything negative starts at bit 0
            for (i = (p < 0) ? 0 : p + 1; i < limit; i++) begin
               if (shadow_map[i >> 5][i & 31]) begin
                  r.found = 1'b1;
                  r.found_position = i[9:0];
                  break;
               end
            end
         end
         KIND_COUNT: begin
            for (i = 0; i < limit / 32; i++) ones += $countones(shadow_map[i]);
            r.bit_count = value ? ones[10:0] : 11'(limit - ones);
         end
         KIND_CLEAR: begin
            for (i = 0; i < WORDS; i++) shadow_map[i] = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_op(logic [2:0] kind, logic signed [10:0] position, logic value,
                           int gap);
      bitmap_op_type op_item;
      op_item.kind = kind;
      op_item.position = position;
      op_item.value = value;
      op_item.gap = gap;
      op_queue.push_back(op_item);
      results_due++;
   endtask

   task automatic queue_random_op(int limit, bit gaps_on);
      logic [2:0] kind;
      logic signed [10:0] position;
      logic value;
      int pick;
      int p;
      pick = $urandom_range(0, 99);
      if (pick < 25) kind = KIND_GET;
      else if (pick < 60) kind = KIND_SET;
      else if (pick < 83) kind = KIND_FIND;
      else if (pick < 91) kind = KIND_COUNT;
      else if (pick < 94) kind = KIND_CLEAR;
      else kind = 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 9);
      if (limit > 0 && pick < 7) begin
         position = 11'($urandom_range(0, limit - 1));
      end else if (pick == 7) begin
         position = -11'sd1;
      end else if (pick == 8 || (limit == 0 && pick < 7)) begin
         position = 11'($urandom_range(0, 2047));
      end else begin
         // around the top of the active range
         p = limit - 1 + $urandom_range(0, 2);
         if (p > 1023) p = 1023;
         position = 11'(p);
      end
      if (kind == KIND_SET) value = ($urandom_range(0, 99) < 65);
      else value = 1'($urandom_range(0, 1));
      queue_op(kind, position, value, gaps_on ? $urandom_range(0, 5) : 0);
   endtask

   task automatic wait_drained();
      while (results_due != 0) @(posedge clock);
   endtask

   task automatic write_words_in_use(logic [WIU_W-1:0] n);
      repeat ($urandom_range(1, 5)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_words_in_use <= n;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      shadow_words_in_use = n;
   endtask

   task automatic flag_mismatch(string what, int want_v, int got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
   endtask

   // request driver
   always @(posedge clock) begin
      bitmap_op_type op_item;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(run_bitmap_op(req_kind, req_position, req_value));
         if (!req_valid || req_ready) begin
            if (op_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if (req_gap_count < op_queue[0].gap) begin
               req_gap_count <= req_gap_count + 1;
               req_valid <= 1'b0;
            end else begin
               op_item = op_queue.pop_front();
               req_valid <= 1'b1;
               req_kind <= op_item.kind;
               req_position <= op_item.position;
               req_value <= op_item.value;
               req_gap_count <= 0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      bitmap_result_type want;
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               flag_mismatch("unexpected result word", 0, 1);
            end else begin
               want = expected_results.pop_front();
               results_due--;
               if (rsp_bit_value !== want.bit_value)
                  flag_mismatch("bit_value", want.bit_value, rsp_bit_value);
               if (rsp_found !== want.found)
                  flag_mismatch("found", want.found, rsp_found);
               if (rsp_found_position !== want.found_position)
                  flag_mismatch("found_position", want.found_position, rsp_found_position);
               if (rsp_bit_count !== want.bit_count)
                  flag_mismatch("bit_count", want.bit_count, rsp_bit_count);
            end
            if ($urandom_range(0, 99) == 0) rsp_stalls_on = !rsp_stalls_on;
            stall = rsp_stalls_on ? $urandom_range(0, 5) : 0;
            rsp_stall <= stall;
            rsp_ready <= (stall == 0);
         end else if (rsp_stall != 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= (rsp_stall == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // counts cycles in which no word moves on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("[bitmap_find_next_set_engine] ERROR");
      $finish;
   end

   initial begin
      int phase_words [10];
      int limit;
      bit gaps_on;
      phase_words = '{1, 32, 0, 63, 33, 7, 16, 2, 0, 0};
      phase_words[8] = $urandom_range(1, 32);
      phase_words[9] = $urandom_range(0, 63);
      for (int i = 0; i < WORDS; i++) shadow_map[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty map, both ends of the bitmap, out-of-range and unused kinds
      queue_op(KIND_COUNT, 11'sd0, 1'b1, 0);
      queue_op(KIND_COUNT, 11'sd0, 1'b0, 0);
      queue_op(KIND_FIND, -11'sd1, 1'b0, 1);
      queue_op(KIND_GET, 11'sd1023, 1'b0, 0);
      queue_op(KIND_SET, 11'sd0, 1'b1, 2);
      queue_op(KIND_SET, 11'sd1023, 1'b1, 0);
      queue_op(KIND_SET, -11'sd1, 1'b1, 0);
      queue_op(KIND_SET, -11'sd1024, 1'b1, 3);
      queue_op(KIND_GET, 11'sd0, 1'b0, 0);
      queue_op(KIND_GET, 11'sd1023, 1'b0, 0);
      queue_op(KIND_GET, -11'sd1, 1'b0, 0);
      queue_op(KIND_GET, -11'sd1024, 1'b0, 5);
      queue_op(KIND_FIND, -11'sd1, 1'b0, 0);
      queue_op(KIND_FIND, 11'sd0, 1'b0, 0);
      queue_op(KIND_FIND, 11'sd1023, 1'b0, 0);
      queue_op(KIND_FIND, -11'sd1024, 1'b0, 1);
      queue_op(KIND_COUNT, 11'sd0, 1'b1, 0);
      queue_op(KIND_COUNT, 11'sd0, 1'b0, 0);
      queue_op(3'd5, 11'sd1023, 1'b1, 0);
      queue_op(3'd6, -11'sd1, 1'b1, 4);
      queue_op(3'd7, 11'sd512, 1'b0, 0);
      queue_op(KIND_SET, 11'sd1023, 1'b0, 0);
      queue_op(KIND_GET, 11'sd1023, 1'b0, 0);
      queue_op(KIND_CLEAR, 11'sd0, 1'b0, 0);
      queue_op(KIND_COUNT, 11'sd0, 1'b1, 0);
      wait_drained();

      for (int ph = 0; ph < 10; ph++) begin
         write_words_in_use(WIU_W'(phase_words[ph]));
         limit = active_bits();
         // bits left over from other settings show up here
         queue_op(KIND_COUNT, 11'sd0, 1'b1, 0);
         queue_op(KIND_FIND, -11'sd1, 1'b0, 0);
         gaps_on = 1'b1;
         for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            queue_random_op(limit, gaps_on);
         end
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0 && results_due == 0)
         $display("[bitmap_find_next_set_engine] OK");
      else
         $display("[bitmap_find_next_set_engine] ERROR");
      $finish;
   end

endmodule

@@ bitmap_find_next_set_engine.f @@
design/bfns_pkg.sv
design/bfns_bitmap_mem.sv
design/bfns_scan_unit.sv
design/bitmap_find_next_set_engine.sv
test/testbench.sv
